>>> rtl/dtsp_pkg.sv
// Shared types and constants for the date-time string parser.
// No dependencies; the other rtl files but dtsp_in_stage refer to it by scoped names.
`timescale 1ns / 1ps

package dtsp_pkg;

  // Character codes checked at fixed positions
  localparam logic [15:0] CHAR_DASH  = 16'h002D;
  localparam logic [15:0] CHAR_SPACE = 16'h0020;
  localparam logic [15:0] CHAR_COLON = 16'h003A;
  localparam logic [15:0] CHAR_ZERO  = 16'h0030;
  localparam logic [15:0] CHAR_NINE  = 16'h0039;

  // Character positions within "YYYY-MM-DD HH:MM:SS"
  localparam logic [4:0] POS_DASH_MON  = 5'd4;
  localparam logic [4:0] POS_DASH_DAY  = 5'd7;
  localparam logic [4:0] POS_SPACE     = 5'd10;
  localparam logic [4:0] POS_COLON_MIN = 5'd13;
  localparam logic [4:0] POS_COLON_SEC = 5'd16;
  localparam logic [4:0] POS_CENT_END  = 5'd2;
  localparam logic [4:0] POS_LAST      = 5'd18;
  localparam logic [4:0] POS_SAT       = 5'd20;

  // Position of the final character for each accepted length
  localparam logic [4:0] POS_END_YEAR   = 5'd3;
  localparam logic [4:0] POS_END_MONTH  = 5'd6;
  localparam logic [4:0] POS_END_DAY    = 5'd9;
  localparam logic [4:0] POS_END_HOUR   = 5'd12;
  localparam logic [4:0] POS_END_MINUTE = 5'd15;
  localparam logic [4:0] POS_END_SECOND = 5'd18;

  // Precision codes
  localparam logic [2:0] PREC_YEAR   = 3'd0;
  localparam logic [2:0] PREC_MONTH  = 3'd1;
  localparam logic [2:0] PREC_DAY    = 3'd2;
  localparam logic [2:0] PREC_HOUR   = 3'd3;
  localparam logic [2:0] PREC_MINUTE = 3'd4;
  localparam logic [2:0] PREC_SECOND = 3'd5;

  // Scanner state; cent and ylo split the year into its top and bottom digit pairs
  typedef struct packed {
    logic [4:0]  pos;
    logic        fmt_err;
    logic [13:0] year;
    logic [6:0]  cent;
    logic [6:0]  ylo;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } scan_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  prec;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } res_t;

endpackage

>>> rtl/date_time_string_parser.sv
// Date-time string parser: checks "YYYY-MM-DD HH:MM:SS" prefixes and returns the fields.
// Depends on dtsp_pkg, dtsp_in_stage, dtsp_scan and dtsp_check.
//
// Input channel (in_valid/in_ready): one 16-bit character word per transfer, with
// last_char high on the final character of a string. Output channel
// (out_valid/out_ready): one result word per string, issued for its final character.
//
// Throughput: one character per cycle, sustained while no final character stalls, set
// by the scan step from the input register into the field accumulators and the result
// register. Latency: the last character of a string is held in the input register,
// and its result is then registered in the output register.
//
// A result waiting in the output register does not block characters that carry on a
// string; only a final character stalls, in the input register, until the output
// register is free or being emptied in the same cycle, and in_ready then drops.
//
// Reset empties the input register and the output register and clears the scan state,
// so the first character after reset starts a new string.
`timescale 1ns / 1ps

module date_time_string_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [2:0]  precision,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic            held;
  logic [15:0]     held_char;
  logic            held_last;
  logic            out_free;
  logic            take;
  dtsp_pkg::scan_t snap;
  dtsp_pkg::res_t  res;
  dtsp_pkg::res_t  res_q;

  assign out_free = !out_valid || out_ready;
  // Hold a final character until there is room for its result
  assign take     = held && (!held_last || out_free);

  dtsp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .take      (take),
    .held      (held),
    .held_char (held_char),
    .held_last (held_last)
  );

  dtsp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (take),
    .char_code (held_char),
    .last_char (held_last),
    .snap      (snap)
  );

  dtsp_check u_check (
    .snap (snap),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && held_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_last) begin
      res_q <= res;
    end
  end

  assign valid_res = res_q.ok;
  assign precision = res_q.prec;
  assign year      = res_q.year;
  assign month     = res_q.month;
  assign day       = res_q.day;
  assign hour      = res_q.hour;
  assign minute    = res_q.minute;
  assign second    = res_q.second;

  // Input may only stall behind a final character whose result cannot be placed
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (precision == 3'd0 && year == 14'd0 && month == 4'd0
      && day == 5'd0 && hour == 5'd0 && minute == 6'd0 && second == 6'd0))
    else $error("rejected string carries nonzero fields");

  a_accept_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |-> (year != 14'd0 && month != 4'd0 && month <= 4'd12
      && day != 5'd0 && precision <= dtsp_pkg::PREC_SECOND))
    else $error("accepted string with out-of-range date");

  a_accept_time: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("accepted string with out-of-range time");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(held) && $past(held_last)))
    else $error("result appeared without a final character");

endmodule

>>> rtl/dtsp_in_stage.sv
// Input register for the date-time string parser: holds one character word.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module dtsp_in_stage (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] char_code,
  input  logic        last_char,
  input  logic        take,
  output logic        held,
  output logic [15:0] held_char,
  output logic        held_last
);

  // A held word leaves in the same cycle a new one may enter
  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= char_code;
      held_last <= last_char;
    end
  end

endmodule

>>> rtl/dtsp_scan.sv
// Position tracking, format checking and decimal accumulation of the fields.
// Depends on dtsp_pkg for scan_t and the position and character constants.
`timescale 1ns / 1ps

module dtsp_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [15:0]         char_code,
  input  logic                last_char,
  output dtsp_pkg::scan_t     snap
);

  dtsp_pkg::scan_t acc;
  dtsp_pkg::scan_t acc_next;
  logic            is_digit;
  logic [3:0]      digit;

  function automatic logic [6:0] dec2(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] t;
    t = 11'(a) * 11'd10 + 11'(d);
    return t[6:0];
  endfunction

  function automatic logic [13:0] dec4(input logic [13:0] a, input logic [3:0] d);
    logic [17:0] t;
    t = 18'(a) * 18'd10 + 18'(d);
    return t[13:0];
  endfunction

  assign is_digit = (char_code >= dtsp_pkg::CHAR_ZERO) && (char_code <= dtsp_pkg::CHAR_NINE);
  assign digit    = char_code[3:0];

  // State as it stands once the held character is taken in; pos is its own position
  always_comb begin
    snap = acc;
    if (acc.pos <= dtsp_pkg::POS_LAST) begin
      priority if (acc.pos == dtsp_pkg::POS_DASH_MON || acc.pos == dtsp_pkg::POS_DASH_DAY) begin
        if (char_code != dtsp_pkg::CHAR_DASH) snap.fmt_err = 1'b1;
      end else if (acc.pos == dtsp_pkg::POS_SPACE) begin
        if (char_code != dtsp_pkg::CHAR_SPACE) snap.fmt_err = 1'b1;
      end else if (acc.pos == dtsp_pkg::POS_COLON_MIN || acc.pos == dtsp_pkg::POS_COLON_SEC) begin
        if (char_code != dtsp_pkg::CHAR_COLON) snap.fmt_err = 1'b1;
      end else if (!is_digit) begin
        snap.fmt_err = 1'b1;
      end else if (acc.pos < dtsp_pkg::POS_DASH_MON) begin
        snap.year = dec4(acc.year, digit);
        if (acc.pos < dtsp_pkg::POS_CENT_END) snap.cent = dec2(acc.cent, digit);
        else snap.ylo = dec2(acc.ylo, digit);
      end else if (acc.pos < dtsp_pkg::POS_DASH_DAY) begin
        snap.month = dec2(acc.month, digit);
      end else if (acc.pos < dtsp_pkg::POS_SPACE) begin
        snap.day = dec2(acc.day, digit);
      end else if (acc.pos < dtsp_pkg::POS_COLON_MIN) begin
        snap.hour = dec2(acc.hour, digit);
      end else if (acc.pos < dtsp_pkg::POS_COLON_SEC) begin
        snap.minute = dec2(acc.minute, digit);
      end else begin
        snap.second = dec2(acc.second, digit);
      end
    end
  end

  always_comb begin
    acc_next = snap;
    if (acc.pos < dtsp_pkg::POS_SAT) acc_next.pos = acc.pos + 5'd1;
  end

  // Start a fresh string after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      if (last_char) acc <= '0;
      else acc <= acc_next;
    end
  end

endmodule

>>> rtl/dtsp_check.sv
// Length decode, defaulting of absent fields and calendar/clock range checks.
// Depends on dtsp_pkg for scan_t, res_t and the precision codes.
`timescale 1ns / 1ps

module dtsp_check (
  input  dtsp_pkg::scan_t snap,
  output dtsp_pkg::res_t  res
);

  logic       len_ok;
  logic [2:0] prec;
  logic [6:0] mo;
  logic [6:0] dd;
  logic [6:0] hh;
  logic [6:0] mi;
  logic [6:0] ss;
  logic       leap;
  logic [4:0] dim;
  logic       ok;

  function automatic logic [4:0] days_in_month(input logic [6:0] m, input logic lp);
    logic [4:0] d;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
      7'd2:                                       d = lp ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  always_comb begin
    len_ok = 1'b1;
    unique case (snap.pos)
      dtsp_pkg::POS_END_YEAR:   prec = dtsp_pkg::PREC_YEAR;
      dtsp_pkg::POS_END_MONTH:  prec = dtsp_pkg::PREC_MONTH;
      dtsp_pkg::POS_END_DAY:    prec = dtsp_pkg::PREC_DAY;
      dtsp_pkg::POS_END_HOUR:   prec = dtsp_pkg::PREC_HOUR;
      dtsp_pkg::POS_END_MINUTE: prec = dtsp_pkg::PREC_MINUTE;
      dtsp_pkg::POS_END_SECOND: prec = dtsp_pkg::PREC_SECOND;
      default: begin
        prec   = dtsp_pkg::PREC_YEAR;
        len_ok = 1'b0;
      end
    endcase
  end

  assign mo = (prec >= dtsp_pkg::PREC_MONTH)  ? snap.month  : 7'd1;
  assign dd = (prec >= dtsp_pkg::PREC_DAY)    ? snap.day    : 7'd1;
  assign hh = (prec >= dtsp_pkg::PREC_HOUR)   ? snap.hour   : 7'd0;
  assign mi = (prec >= dtsp_pkg::PREC_MINUTE) ? snap.minute : 7'd0;
  assign ss = (prec >= dtsp_pkg::PREC_SECOND) ? snap.second : 7'd0;

  // Divisible by 4, and either not a whole century or a century divisible by 4
  assign leap = (snap.year[1:0] == 2'd0) && ((snap.ylo != 7'd0) || (snap.cent[1:0] == 2'd0));
  assign dim  = days_in_month(mo, leap);

  assign ok = !snap.fmt_err && len_ok && (snap.year != 14'd0)
              && (mo >= 7'd1) && (mo <= 7'd12) && (dd >= 7'd1) && (dd <= {2'b00, dim})
              && (hh <= 7'd23) && (mi <= 7'd59) && (ss <= 7'd59);

  always_comb begin
    res = '0;
    if (ok) begin
      res.ok     = 1'b1;
      res.prec   = prec;
      res.year   = snap.year;
      res.month  = mo[3:0];
      res.day    = dd[4:0];
      res.hour   = hh[4:0];
      res.minute = mi[5:0];
      res.second = ss[5:0];
    end
  end

endmodule

>>> verif/testbench.sv
// Self-checking bench for date_time_string_parser: character words in, parsed fields out.
// Depends on dtsp_pkg and the rtl top; holds its own scanner model of the parser.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1250;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] char_code;
  logic        last_char;
  logic        out_valid;
  logic        out_ready;
  logic        valid_res;
  logic [2:0]  precision;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  date_time_string_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .last_char(last_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .valid_res(valid_res), .precision(precision),
    .year(year), .month(month), .day(day),
    .hour(hour), .minute(minute), .second(second)
  );

  // Scanner model state
  logic [4:0]  scan_pos;
  logic        scan_bad;
  logic [13:0] acc_year;
  logic [6:0]  acc_mon, acc_day, acc_hour, acc_min, acc_sec;

  dtsp_pkg::res_t parsed_q[$];
  logic [15:0]    word_buf[$];
  int             idle_pct;
  int             words_sent;
  int             mismatches;
  int             cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int month_len(input int y, input int m);
    int lens[12];
    logic leap;
    lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m == 2 && leap) return 29;
    return lens[m - 1];
  endfunction

  task automatic clear_scan();
    scan_pos = '0;
    scan_bad = 1'b0;
    acc_year = '0;
    acc_mon  = '0;
    acc_day  = '0;
    acc_hour = '0;
    acc_min  = '0;
    acc_sec  = '0;
  endtask

  // Advance the scanner by one accepted word; queue the parse result on the last one
  task automatic scan_char(input logic [15:0] c, input logic lst);
    logic [4:0]     p;
    logic           is_dig;
    int             dv;
    logic [2:0]     pr;
    logic           ok;
    int             y, mo, dd, h, mi, s;
    dtsp_pkg::res_t r;
    p = scan_pos;
    is_dig = (c >= dtsp_pkg::CHAR_ZERO) && (c <= dtsp_pkg::CHAR_NINE);
    dv = is_dig ? int'(c - dtsp_pkg::CHAR_ZERO) : 0;
    if (p <= dtsp_pkg::POS_LAST) begin
      if (p == dtsp_pkg::POS_DASH_MON || p == dtsp_pkg::POS_DASH_DAY) begin
        if (c != dtsp_pkg::CHAR_DASH) scan_bad = 1'b1;
      end else if (p == dtsp_pkg::POS_SPACE) begin
        if (c != dtsp_pkg::CHAR_SPACE) scan_bad = 1'b1;
      end else if (p == dtsp_pkg::POS_COLON_MIN || p == dtsp_pkg::POS_COLON_SEC) begin
        if (c != dtsp_pkg::CHAR_COLON) scan_bad = 1'b1;
      end else if (!is_dig) begin
        scan_bad = 1'b1;
      end else if (p < dtsp_pkg::POS_DASH_MON) begin
        acc_year = 14'(int'(acc_year) * 10 + dv);
      end else if (p < dtsp_pkg::POS_DASH_DAY) begin
        acc_mon = 7'(int'(acc_mon) * 10 + dv);
      end else if (p < dtsp_pkg::POS_SPACE) begin
        acc_day = 7'(int'(acc_day) * 10 + dv);
      end else if (p < dtsp_pkg::POS_COLON_MIN) begin
        acc_hour = 7'(int'(acc_hour) * 10 + dv);
      end else if (p < dtsp_pkg::POS_COLON_SEC) begin
        acc_min = 7'(int'(acc_min) * 10 + dv);
      end else begin
        acc_sec = 7'(int'(acc_sec) * 10 + dv);
      end
    end
    if (scan_pos < dtsp_pkg::POS_SAT) scan_pos = scan_pos + 5'd1;
    if (lst) begin
      ok = !scan_bad;
      case (p)
        dtsp_pkg::POS_END_YEAR:   pr = dtsp_pkg::PREC_YEAR;
        dtsp_pkg::POS_END_MONTH:  pr = dtsp_pkg::PREC_MONTH;
        dtsp_pkg::POS_END_DAY:    pr = dtsp_pkg::PREC_DAY;
        dtsp_pkg::POS_END_HOUR:   pr = dtsp_pkg::PREC_HOUR;
        dtsp_pkg::POS_END_MINUTE: pr = dtsp_pkg::PREC_MINUTE;
        dtsp_pkg::POS_END_SECOND: pr = dtsp_pkg::PREC_SECOND;
        default: begin
          pr = dtsp_pkg::PREC_YEAR;
          ok = 1'b0;
        end
      endcase
      y  = acc_year;
      mo = (pr >= dtsp_pkg::PREC_MONTH)  ? int'(acc_mon)  : 1;
      dd = (pr >= dtsp_pkg::PREC_DAY)    ? int'(acc_day)  : 1;
      h  = (pr >= dtsp_pkg::PREC_HOUR)   ? int'(acc_hour) : 0;
      mi = (pr >= dtsp_pkg::PREC_MINUTE) ? int'(acc_min)  : 0;
      s  = (pr >= dtsp_pkg::PREC_SECOND) ? int'(acc_sec)  : 0;
      if (y == 0 || mo < 1 || mo > 12 || dd < 1 || dd > month_len(y, mo)) ok = 1'b0;
      if (h > 23 || mi > 59 || s > 59) ok = 1'b0;
      r = '0;
      if (ok) begin
        r.ok     = 1'b1;
        r.prec   = pr;
        r.year   = 14'(y);
        r.month  = 4'(mo);
        r.day    = 5'(dd);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
      end
      parsed_q.push_back(r);
      clear_scan();
    end
  endtask

  // Compare every accepted result word with the oldest parse still owed
  always @(posedge clk) begin : check_results
    dtsp_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        report_mismatch("unexpected result word", valid_res, 0);
      end else begin
        want = parsed_q.pop_front();
        if (valid_res !== want.ok)     report_mismatch("valid_res", valid_res, want.ok);
        if (precision !== want.prec)   report_mismatch("precision", precision, want.prec);
        if (year !== want.year)        report_mismatch("year", year, want.year);
        if (month !== want.month)      report_mismatch("month", month, want.month);
        if (day !== want.day)          report_mismatch("day", day, want.day);
        if (hour !== want.hour)        report_mismatch("hour", hour, want.hour);
        if (minute !== want.minute)    report_mismatch("minute", minute, want.minute);
        if (second !== want.second)    report_mismatch("second", second, want.second);
      end
    end
  end

  // Result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_char(input logic [15:0] c, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_char(c, lst);
    words_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < word_buf.size(); i++)
      send_char(word_buf[i], i == word_buf.size() - 1);
    word_buf.delete();
  endtask

  // Drop valid first so the last word is not taken again while waiting
  task automatic wait_parses_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(16'(s[i]));
  endtask

  task automatic put_digits(input int val, input int n);
    int div;
    for (int k = n - 1; k >= 0; k--) begin
      div = 1;
      for (int j = 0; j < k; j++) div = div * 10;
      word_buf.push_back(dtsp_pkg::CHAR_ZERO + 16'((val / div) % 10));
    end
  endtask

  function automatic int pick_year();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 10) return 9999;
    if (r < 25) return 400 * $urandom_range(0, 24);
    if (r < 35) return 100 * $urandom_range(1, 99);
    if (r < 55) return 4 * $urandom_range(1, 2499);
    return $urandom_range(1, 9999);
  endfunction

  // Mostly in range, with the edges and just past them favoured
  function automatic int pick_num(input int lo, input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(lo, hi);
    if (r < 80) return hi;
    if (r < 88) return lo;
    if (r < 91) return (lo > 0) ? lo - 1 : hi + 1;
    if (r < 94) return hi + 1;
    return $urandom_range(0, 99);
  endfunction

  function automatic int pick_day();
    if ($urandom_range(99) < 30) return $urandom_range(28, 31);
    return pick_num(1, 31);
  endfunction

  function automatic logic [15:0] pick_noise();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom_range(0, 65535));
    if (r < 70) return dtsp_pkg::CHAR_ZERO + 16'($urandom_range(0, 9));
    case ($urandom_range(4))
      0:       return dtsp_pkg::CHAR_DASH;
      1:       return dtsp_pkg::CHAR_SPACE;
      2:       return dtsp_pkg::CHAR_COLON;
      3:       return dtsp_pkg::CHAR_ZERO - 16'd1;
      default: return dtsp_pkg::CHAR_NINE + 16'd1;
    endcase
  endfunction

  task automatic build_wellformed(input int prec);
    put_digits(pick_year(), 4);
    if (prec >= dtsp_pkg::PREC_MONTH) begin
      word_buf.push_back(dtsp_pkg::CHAR_DASH);
      put_digits(pick_num(1, 12), 2);
    end
    if (prec >= dtsp_pkg::PREC_DAY) begin
      word_buf.push_back(dtsp_pkg::CHAR_DASH);
      put_digits(pick_day(), 2);
    end
    if (prec >= dtsp_pkg::PREC_HOUR) begin
      word_buf.push_back(dtsp_pkg::CHAR_SPACE);
      put_digits(pick_num(0, 23), 2);
    end
    if (prec >= dtsp_pkg::PREC_MINUTE) begin
      word_buf.push_back(dtsp_pkg::CHAR_COLON);
      put_digits(pick_num(0, 59), 2);
    end
    if (prec >= dtsp_pkg::PREC_SECOND) begin
      word_buf.push_back(dtsp_pkg::CHAR_COLON);
      put_digits(pick_num(0, 59), 2);
    end
  endtask

  // Single-word strings at the code extremes, and the largest year
  task automatic test_format_edges();
    word_buf.push_back(16'hFFFF);
    send_buffer();
    word_buf.push_back(16'h0000);
    send_buffer();
    put_text("9999");
    send_buffer();
  endtask

  // Year zero, a century leap day and a month-only string
  task automatic test_calendar_edges();
    put_text("0000");
    send_buffer();
    put_text("2000-02-29");
    send_buffer();
    put_text("1999-12");
    send_buffer();
  endtask

  task automatic test_random_strings();
    int first_word;
    int strings;
    int kind;
    int idx;
    first_word = words_sent;
    strings = 0;
    while (words_sent - first_word < RANDOM_WORDS) begin
      // long burst with no idling on either side
      idle_pct = (strings >= 30 && strings < 50) ? 0 : 11;
      if (strings == 70) wait_parses_drained();
      kind = $urandom_range(99);
      if (kind < 72) begin
        build_wellformed($urandom_range(dtsp_pkg::PREC_YEAR, dtsp_pkg::PREC_SECOND));
      end else if (kind < 87) begin
        build_wellformed($urandom_range(dtsp_pkg::PREC_YEAR, dtsp_pkg::PREC_SECOND));
        idx = $urandom_range(0, word_buf.size() - 1);
        word_buf[idx] = pick_noise();
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 25)) word_buf.push_back(pick_noise());
      end else begin
        // full string run on past its end
        build_wellformed(dtsp_pkg::PREC_SECOND);
        repeat ($urandom_range(1, 6)) word_buf.push_back(pick_noise());
      end
      send_buffer();
      strings++;
    end
    idle_pct = 11;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    char_code   = '0;
    last_char   = 1'b0;
    idle_pct    = 11;
    words_sent  = 0;
    mismatches  = 0;
    clear_scan();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_format_edges();
    test_calendar_edges();
    wait_parses_drained();
    test_random_strings();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_parses_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
